[rtl/core/b64b32_pkg.sv]
// Shared types, constants and alphabet functions of the base64/base32 stream codec.
// No dependencies; every other file takes from here by scoped names.
package b64b32_pkg;

    localparam logic [7:0] PAD_CHAR     = 8'h3D;
    localparam logic [7:0] NEWLINE_CHAR = 8'h0A;

    localparam logic [1:0] REG_DECODE_MODE    = 2'd0;
    localparam logic [1:0] REG_RADIX_SELECT   = 2'd1;
    localparam logic [1:0] REG_WRAP_COLUMNS   = 2'd2;
    localparam logic [1:0] REG_IGNORE_GARBAGE = 2'd3;

    localparam logic [15:0] WRAP_RESET = 16'd76;

    localparam logic [1:0] JOB_SYMS  = 2'd0;
    localparam logic [1:0] JOB_FLUSH = 2'd1;
    localparam logic [1:0] JOB_BYTE  = 2'd2;

    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    typedef struct packed {
        logic        decode_mode;
        logic        radix_select;
        logic [15:0] wrap_columns;
        logic        ignore_garbage;
    } t_cfg;

    typedef struct packed {
        logic [1:0] kind;
        logic [1:0] nsym;
        logic [5:0] sym0;
        logic [5:0] sym1;
        logic [7:0] data;
    } t_job;

    function automatic logic [7:0] symbol_char(input logic [5:0] v, input logic radix);
        logic [5:0] m;
        logic [7:0] c;
        begin
            m = radix ? {1'b0, v[4:0]} : v;
            if (m < 6'd26) begin
                c = 8'h41 + {2'b00, m};
            end else if (radix) begin
                c = 8'h32 + {2'b00, m} - 8'd26;
            end else if (m < 6'd52) begin
                c = 8'h61 + {2'b00, m} - 8'd26;
            end else if (m < 6'd62) begin
                c = 8'h30 + {2'b00, m} - 8'd52;
            end else if (m == 6'd62) begin
                c = 8'h2B;
            end else begin
                c = 8'h2F;
            end
            return c;
        end
    endfunction

    // bit 6 set when the character belongs to the selected alphabet
    function automatic logic [6:0] symbol_value(input logic [7:0] c, input logic radix);
        logic [6:0] r;
        begin
            r = 7'd0;
            if (c >= 8'h41 && c <= 8'h5A) begin
                r = {1'b1, 6'(c - 8'h41)};
            end else if (radix) begin
                if (c >= 8'h32 && c <= 8'h37) r = {1'b1, 6'(c - 8'h32 + 8'd26)};
            end else if (c >= 8'h61 && c <= 8'h7A) begin
                r = {1'b1, 6'(c - 8'h61 + 8'd26)};
            end else if (c >= 8'h30 && c <= 8'h39) begin
                r = {1'b1, 6'(c - 8'h30 + 8'd52)};
            end else if (c == 8'h2B) begin
                r = {1'b1, 6'd62};
            end else if (c == 8'h2F) begin
                r = {1'b1, 6'd63};
            end
            return r;
        end
    endfunction

    function automatic logic [13:0] low_mask(input logic [3:0] n);
        return 14'((15'd1 << n) - 15'd1);
    endfunction

endpackage

[rtl/core/base64_base32_stream_codec.sv]
// Streaming base64/base32 encoder and decoder. An input byte is taken in every cycle
// while the four-entry job queue has room; the output sequencer delivers one character
// per cycle while the output is not stalled. An encoded byte yields one to four characters
// (symbols plus newlines), a decoded character at most one byte, and an end-of-stream
// flush any last partial symbol, padding and newline. When encoding, the output limits the rate.
// Depends on b64b32_pkg, b64b32_front, b64b32_fifo and b64b32_back.
module base64_base32_stream_codec (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_in_byte,
    input  logic        i_end_of_stream,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_out_char,
    output logic        o_last
);

    b64b32_pkg::t_cfg r_cfg;
    logic             w_clear;
    logic             w_push, w_pop, w_full, w_q_valid;
    b64b32_pkg::t_job w_job_in, w_job_out;

    assign w_clear = i_cfg_we && (i_cfg_index == b64b32_pkg::REG_DECODE_MODE
                               || i_cfg_index == b64b32_pkg::REG_RADIX_SELECT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.decode_mode    <= 1'b0;
            r_cfg.radix_select   <= 1'b0;
            r_cfg.wrap_columns   <= b64b32_pkg::WRAP_RESET;
            r_cfg.ignore_garbage <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                b64b32_pkg::REG_DECODE_MODE:  r_cfg.decode_mode    <= i_cfg_data[0];
                b64b32_pkg::REG_RADIX_SELECT: r_cfg.radix_select   <= i_cfg_data[0];
                b64b32_pkg::REG_WRAP_COLUMNS: r_cfg.wrap_columns   <= i_cfg_data;
                default:                      r_cfg.ignore_garbage <= i_cfg_data[0];
            endcase
        end
    end

    b64b32_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (r_cfg),
        .i_clear         (w_clear),
        .i_in_valid      (i_in_valid),
        .i_in_byte       (i_in_byte),
        .i_end_of_stream (i_end_of_stream),
        .i_q_full        (w_full),
        .o_in_stall      (o_in_stall),
        .o_push          (w_push),
        .o_job           (w_job_in)
    );

    b64b32_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_job_in),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_valid (w_q_valid),
        .o_job   (w_job_out)
    );

    b64b32_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_clear     (w_clear),
        .i_q_valid   (w_q_valid),
        .i_job       (w_job_out),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_char  (o_out_char),
        .o_last      (o_last)
    );

endmodule

[rtl/core/b64b32_front.sv]
// Front end: accepts items, packs or unpacks bits and queues output jobs.
// Depends on b64b32_pkg.
module b64b32_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  b64b32_pkg::t_cfg      i_cfg,
    input  logic                  i_clear,
    input  logic                  i_in_valid,
    input  logic [7:0]            i_in_byte,
    input  logic                  i_end_of_stream,
    input  logic                  i_q_full,
    output logic                  o_in_stall,
    output logic                  o_push,
    output b64b32_pkg::t_job      o_job
);

    logic [13:0] r_acc, n_acc;
    logic [3:0]  r_cnt, n_cnt;
    logic        r_halted, n_halted;

    logic        w_accept;
    logic [3:0]  w_nbits;
    logic [13:0] w_acc_e;
    logic [3:0]  w_cnt_e, w_c1, w_c2, w_cf;
    logic        w_two;
    logic [6:0]  w_sv;
    logic [13:0] w_acc_d;
    logic [3:0]  w_cd, w_cd2;
    logic        w_ge8;

    assign o_in_stall = i_q_full;
    assign w_accept   = i_in_valid && !i_q_full;

    always_comb begin
        w_nbits = i_cfg.radix_select ? 4'd5 : 4'd6;
        w_acc_e = {r_acc[5:0], i_in_byte};
        w_cnt_e = r_cnt + 4'd8;
        w_c1    = w_cnt_e - w_nbits;
        w_two   = w_c1 >= w_nbits;
        w_c2    = w_c1 - w_nbits;
        w_cf    = w_two ? w_c2 : w_c1;
        w_sv    = b64b32_pkg::symbol_value(i_in_byte, i_cfg.radix_select);
        w_acc_d = 14'(r_acc << w_nbits) | {8'd0, w_sv[5:0]};
        w_cd    = r_cnt + w_nbits;
        w_ge8   = w_cd >= 4'd8;
        w_cd2   = w_cd - 4'd8;
    end

    always_comb begin
        n_acc    = r_acc;
        n_cnt    = r_cnt;
        n_halted = r_halted;
        o_push   = 1'b0;
        o_job    = '0;
        if (i_clear) begin
            n_acc    = '0;
            n_cnt    = '0;
            n_halted = 1'b0;
        end else if (w_accept) begin
            if (!i_cfg.decode_mode) begin
                o_push = 1'b1;
                if (i_end_of_stream) begin
                    o_job.kind = b64b32_pkg::JOB_FLUSH;
                    o_job.nsym = (r_cnt != 4'd0 && r_cnt < w_nbits) ? 2'd1 : 2'd0;
                    o_job.sym0 = 6'(r_acc << (w_nbits - r_cnt));
                    n_acc      = '0;
                    n_cnt      = '0;
                    n_halted   = 1'b0;
                end else begin
                    o_job.kind = b64b32_pkg::JOB_SYMS;
                    o_job.nsym = w_two ? 2'd2 : 2'd1;
                    o_job.sym0 = 6'(w_acc_e >> w_c1);
                    o_job.sym1 = 6'(w_acc_e >> w_c2);
                    n_acc      = w_acc_e & b64b32_pkg::low_mask(w_cf);
                    n_cnt      = w_cf;
                end
            end else if (i_end_of_stream) begin
                n_acc    = '0;
                n_cnt    = '0;
                n_halted = 1'b0;
            end else if (!r_halted) begin
                if (i_in_byte == b64b32_pkg::PAD_CHAR) begin
                    n_halted = 1'b1;
                end else if (w_sv[6]) begin
                    if (w_ge8) begin
                        o_push     = 1'b1;
                        o_job.kind = b64b32_pkg::JOB_BYTE;
                        o_job.data = 8'(w_acc_d >> w_cd2);
                        n_acc      = w_acc_d & b64b32_pkg::low_mask(w_cd2);
                        n_cnt      = w_cd2;
                    end else begin
                        n_acc = w_acc_d;
                        n_cnt = w_cd;
                    end
                end else if (i_in_byte != b64b32_pkg::NEWLINE_CHAR
                             && !i_cfg.ignore_garbage) begin
                    n_halted = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc    <= '0;
            r_cnt    <= '0;
            r_halted <= 1'b0;
        end else begin
            r_acc    <= n_acc;
            r_cnt    <= n_cnt;
            r_halted <= n_halted;
        end
    end

endmodule

[rtl/core/b64b32_fifo.sv]
// Job queue between the front end and the output sequencer.
// Depends on b64b32_pkg.
module b64b32_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  b64b32_pkg::t_job  i_job,
    input  logic              i_pop,
    output logic              o_full,
    output logic              o_valid,
    output b64b32_pkg::t_job  o_job
);

    localparam int AW = b64b32_pkg::Q_AW;

    b64b32_pkg::t_job r_mem [b64b32_pkg::Q_DEPTH];
    logic [AW-1:0]    r_wr, r_rd;
    logic [AW:0]      r_count;
    logic             w_push, w_pop;

    assign o_full  = r_count == (AW+1)'(b64b32_pkg::Q_DEPTH);
    assign o_valid = r_count != '0;
    assign o_job   = r_mem[r_rd];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (w_push) r_wr <= r_wr + 1'b1;
            if (w_pop)  r_rd <= r_rd + 1'b1;
            r_count <= r_count + (AW+1)'(w_push) - (AW+1)'(w_pop);
        end
    end

endmodule

[rtl/core/b64b32_back.sv]
// Output sequencer: expands queued jobs into characters, wraps lines, pads groups.
// Depends on b64b32_pkg.
module b64b32_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  b64b32_pkg::t_cfg  i_cfg,
    input  logic              i_clear,
    input  logic              i_q_valid,
    input  b64b32_pkg::t_job  i_job,
    output logic              o_pop,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [7:0]        o_out_char,
    output logic              o_last
);

    localparam logic [2:0] ST_START = 3'd0;
    localparam logic [2:0] ST_SYM   = 3'd1;
    localparam logic [2:0] ST_NL    = 3'd2;
    localparam logic [2:0] ST_PAD   = 3'd3;
    localparam logic [2:0] ST_END   = 3'd4;
    localparam logic [2:0] ST_BYTE  = 3'd5;
    localparam logic [2:0] ST_DONE  = 3'd6;

    logic [2:0]  r_phase, n_phase;
    logic        r_idx, n_idx;
    logic [15:0] r_col, n_col;
    logic [2:0]  r_mod8, n_mod8;
    logic        r_out_valid;
    logic [7:0]  r_out_char;
    logic        r_out_last;

    logic        w_slot, w_adv, w_flush, w_more, w_nl, w_emit, w_last;
    logic [2:0]  w_align, w_eff, w_nxt;
    logic        w_eff_idx;
    logic [15:0] w_col_inc, w_col_w;
    logic [2:0]  w_mod8_w;
    logic [7:0]  w_char;

    function automatic logic [2:0] next_step(input logic is_flush, input logic more,
                                             input logic [15:0] col,
                                             input logic [2:0] mod8,
                                             input logic [2:0] align);
        logic [2:0] s;
        begin
            if (more) begin
                s = ST_SYM;
            end else if (is_flush && (mod8 & align) != 3'd0) begin
                s = ST_PAD;
            end else if (is_flush && col != 16'd0) begin
                s = ST_END;
            end else begin
                s = ST_DONE;
            end
            return s;
        end
    endfunction

    assign w_slot  = !r_out_valid || !i_out_stall;
    assign w_adv   = i_q_valid && w_slot;
    assign w_flush = i_job.kind == b64b32_pkg::JOB_FLUSH;
    assign w_align = i_cfg.radix_select ? 3'd7 : 3'd3;

    always_comb begin
        if (r_phase == ST_START) begin
            w_eff_idx = 1'b0;
            if (i_job.kind == b64b32_pkg::JOB_BYTE) begin
                w_eff = ST_BYTE;
            end else if (i_job.nsym != 2'd0) begin
                w_eff = ST_SYM;
            end else begin
                w_eff = next_step(w_flush, 1'b0, r_col, r_mod8, w_align);
            end
        end else begin
            w_eff_idx = r_idx;
            w_eff     = r_phase;
        end
        w_more    = !w_eff_idx && i_job.nsym == 2'd2;
        w_col_inc = r_col + 16'd1;
        w_nl      = i_cfg.wrap_columns != 16'd0 && w_col_inc == i_cfg.wrap_columns;
        w_col_w   = (i_cfg.wrap_columns == 16'd0) ? r_col : (w_nl ? 16'd0 : w_col_inc);
        w_mod8_w  = r_mod8 + 3'd1;
    end

    always_comb begin
        n_phase = r_phase;
        n_idx   = r_idx;
        n_col   = r_col;
        n_mod8  = r_mod8;
        w_emit  = 1'b0;
        w_last  = 1'b0;
        w_char  = b64b32_pkg::NEWLINE_CHAR;
        w_nxt   = ST_DONE;
        if (i_clear) begin
            n_phase = ST_START;
            n_idx   = 1'b0;
            n_col   = '0;
            n_mod8  = '0;
        end else if (w_adv) begin
            unique case (w_eff)
                ST_SYM, ST_PAD: begin
                    w_emit = 1'b1;
                    w_char = (w_eff == ST_SYM)
                           ? b64b32_pkg::symbol_char(w_eff_idx ? i_job.sym1 : i_job.sym0,
                                                     i_cfg.radix_select)
                           : b64b32_pkg::PAD_CHAR;
                    n_col  = w_col_w;
                    n_mod8 = w_mod8_w;
                    n_idx  = w_eff_idx;
                    w_nxt  = next_step(w_flush, (w_eff == ST_SYM) && w_more,
                                       w_col_w, w_mod8_w, w_align);
                    if (w_nl) begin
                        n_phase = ST_NL;
                    end else begin
                        w_last = w_nxt == ST_DONE;
                    end
                end
                ST_NL: begin
                    w_emit = 1'b1;
                    w_nxt  = next_step(w_flush, w_more, r_col, r_mod8, w_align);
                    w_last = w_nxt == ST_DONE;
                end
                ST_END: begin
                    w_emit = 1'b1;
                    w_last = 1'b1;
                end
                ST_BYTE: begin
                    w_emit = 1'b1;
                    w_char = i_job.data;
                    w_last = 1'b1;
                end
                default: begin
                    w_last = 1'b1;
                end
            endcase
            if (!(w_eff == ST_SYM || w_eff == ST_PAD) || !w_nl) begin
                if (w_last) begin
                    n_phase = ST_START;
                    n_idx   = 1'b0;
                    if (w_flush) begin
                        n_col  = '0;
                        n_mod8 = '0;
                    end
                end else if (w_nxt == ST_SYM) begin
                    n_phase = ST_SYM;
                    n_idx   = 1'b1;
                end else begin
                    n_phase = w_nxt;
                end
            end
        end
    end

    assign o_pop       = w_adv && !i_clear && w_last;
    assign o_out_valid = r_out_valid;
    assign o_out_char  = r_out_char;
    assign o_last      = r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= ST_START;
            r_idx       <= 1'b0;
            r_col       <= '0;
            r_mod8      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_idx   <= n_idx;
            r_col   <= n_col;
            r_mod8  <= n_mod8;
            if (w_slot) begin
                r_out_valid <= w_emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_slot && w_emit) begin
            r_out_char <= w_char;
            r_out_last <= w_last;
        end
    end

endmodule
